/* sv/hdws_pkg.sv */
// Package with the shared types and constants of the handler deque with swap.
`default_nettype none

package hdws_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int WORD_W        = 32;
    localparam int COUNT_W       = 5;

    typedef enum logic [2:0] {
        CMD_PUT_BACK   = 3'd0,
        CMD_POP_BACK   = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_PEEK_FRONT = 3'd3,
        CMD_PEEK_BACK  = 3'd4,
        CMD_CLEAR      = 3'd5,
        CMD_SWAP       = 3'd6
    } cmd_t;

    typedef enum logic [1:0] {
        STS_OK        = 2'd0,
        STS_EMPTY     = 2'd1,
        STS_FULL      = 2'd2,
        STS_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_READ,
        ST_SCAN,
        ST_SWAP_SECOND
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    load;
        logic    put;
        logic    rd_front;
        logic    rd_back;
        logic    drop_front;
        logic    drop_back;
        logic    clear;
        logic    scan_start;
        logic    scan_step;
        logic    swap_first;
        logic    swap_second;
        logic    resp;
        logic    resp_use_rd;
        status_t resp_status;
    } ctl_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        cmd_t cmd;
        logic empty;
        logic full;
        logic scan_done;
        logic both_found;
    } sts_t;

endpackage

`default_nettype wire

/* sv/hdws_ctrl.sv */
// Controller state machine that sequences each deque transaction.
`default_nettype none

module hdws_ctrl
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire hdws_pkg::sts_t sts,
    output hdws_pkg::ctl_t     ctl,
    output logic               busy
);

    hdws_pkg::state_t state_reg;
    hdws_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= hdws_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            hdws_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = hdws_pkg::ST_DECODE;
                end
            end
            hdws_pkg::ST_DECODE:
            begin
                unique case (sts.cmd) inside
                    hdws_pkg::CMD_POP_BACK, hdws_pkg::CMD_POP_FRONT,
                    hdws_pkg::CMD_PEEK_FRONT, hdws_pkg::CMD_PEEK_BACK:
                    begin
                        state_next = sts.empty ? hdws_pkg::ST_IDLE : hdws_pkg::ST_READ;
                    end
                    hdws_pkg::CMD_SWAP:
                    begin
                        state_next = hdws_pkg::ST_SCAN;
                    end
                    default:
                    begin
                        state_next = hdws_pkg::ST_IDLE;
                    end
                endcase
            end
            hdws_pkg::ST_READ:
            begin
                state_next = hdws_pkg::ST_IDLE;
            end
            hdws_pkg::ST_SCAN:
            begin
                if (sts.scan_done)
                begin
                    state_next = sts.both_found ? hdws_pkg::ST_SWAP_SECOND
                                                : hdws_pkg::ST_IDLE;
                end
            end
            hdws_pkg::ST_SWAP_SECOND:
            begin
                state_next = hdws_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = hdws_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs.
    always_comb
    begin
        ctl             = '0;
        ctl.resp_status = hdws_pkg::STS_OK;
        busy            = 1'b1;
        unique case (state_reg)
            hdws_pkg::ST_IDLE:
            begin
                busy     = 1'b0;
                ctl.load = start;
            end
            hdws_pkg::ST_DECODE:
            begin
                unique case (sts.cmd) inside
                    hdws_pkg::CMD_PUT_BACK:
                    begin
                        ctl.resp = 1'b1;
                        if (sts.full)
                        begin
                            ctl.resp_status = hdws_pkg::STS_FULL;
                        end
                        else
                        begin
                            ctl.put = 1'b1;
                        end
                    end
                    hdws_pkg::CMD_POP_BACK, hdws_pkg::CMD_PEEK_BACK:
                    begin
                        if (sts.empty)
                        begin
                            ctl.resp        = 1'b1;
                            ctl.resp_status = hdws_pkg::STS_EMPTY;
                        end
                        else
                        begin
                            ctl.rd_back = 1'b1;
                        end
                    end
                    hdws_pkg::CMD_POP_FRONT, hdws_pkg::CMD_PEEK_FRONT:
                    begin
                        if (sts.empty)
                        begin
                            ctl.resp        = 1'b1;
                            ctl.resp_status = hdws_pkg::STS_EMPTY;
                        end
                        else
                        begin
                            ctl.rd_front = 1'b1;
                        end
                    end
                    hdws_pkg::CMD_CLEAR:
                    begin
                        ctl.clear = 1'b1;
                        ctl.resp  = 1'b1;
                    end
                    hdws_pkg::CMD_SWAP:
                    begin
                        ctl.scan_start = 1'b1;
                    end
                    default:
                    begin
                        ctl.resp = 1'b1;
                    end
                endcase
            end
            hdws_pkg::ST_READ:
            begin
                ctl.resp        = 1'b1;
                ctl.resp_use_rd = 1'b1;
                ctl.drop_back   = (sts.cmd == hdws_pkg::CMD_POP_BACK);
                ctl.drop_front  = (sts.cmd == hdws_pkg::CMD_POP_FRONT);
            end
            hdws_pkg::ST_SCAN:
            begin
                ctl.scan_step = 1'b1;
                if (sts.scan_done)
                begin
                    if (sts.both_found)
                    begin
                        ctl.swap_first = 1'b1;
                    end
                    else
                    begin
                        ctl.resp        = 1'b1;
                        ctl.resp_status = hdws_pkg::STS_NOT_FOUND;
                    end
                end
            end
            hdws_pkg::ST_SWAP_SECOND:
            begin
                ctl.swap_second = 1'b1;
                ctl.resp        = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

endmodule

`default_nettype wire

/* sv/hdws_dp.sv */
// Datapath of the handler deque: slot memory, ring pointer and fill count, search and result registers.
`default_nettype none

module hdws_dp
#(
    parameter int DEPTH = hdws_pkg::DEPTH_DEFAULT
)
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic [2:0]                     cmd,
    input  wire logic [hdws_pkg::WORD_W-1:0]    handler,
    input  wire logic [hdws_pkg::WORD_W-1:0]    other_handler,
    input  wire hdws_pkg::ctl_t                 ctl,
    output hdws_pkg::sts_t                      sts,
    output logic [hdws_pkg::WORD_W-1:0]         value,
    output logic [1:0]                          status,
    output logic [hdws_pkg::COUNT_W-1:0]        count,
    output logic                                done
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [IDX_W:0]   DEPTH_IDX = (IDX_W + 1)'(DEPTH);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

    // Ring position of an offset from a base, both below DEPTH.
    function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] base,
                                                  input logic [IDX_W-1:0] off);
        logic [IDX_W:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= DEPTH_IDX)
        begin
            sum = sum - DEPTH_IDX;
        end
        return sum[IDX_W-1:0];
    endfunction

    logic [hdws_pkg::WORD_W-1:0] slots_mem [DEPTH];

    hdws_pkg::cmd_t              cmd_reg;
    logic [hdws_pkg::WORD_W-1:0] h1_reg;
    logic [hdws_pkg::WORD_W-1:0] h2_reg;
    logic [IDX_W-1:0]            front_reg;
    logic [IDX_W-1:0]            front_next;
    logic [CNT_W-1:0]            cnt_reg;
    logic [CNT_W-1:0]            cnt_next;
    logic [CNT_W-1:0]            cnt_dec;
    logic [CNT_W-1:0]            k_reg;
    logic                        rd_pend_reg;
    logic [IDX_W-1:0]            pos_d_reg;
    logic                        f1_reg;
    logic                        f2_reg;
    logic [IDX_W-1:0]            p1_reg;
    logic [IDX_W-1:0]            p2_reg;
    logic [hdws_pkg::WORD_W-1:0] rd_data_reg;
    logic [hdws_pkg::WORD_W-1:0] value_reg;
    hdws_pkg::status_t           status_reg;
    logic [hdws_pkg::COUNT_W-1:0] count_reg;
    logic                        done_reg;

    logic                        scan_issue;
    logic [IDX_W-1:0]            scan_addr;
    logic                        mem_we;
    logic [IDX_W-1:0]            wr_addr;
    logic [hdws_pkg::WORD_W-1:0] wr_data;
    logic                        mem_re;
    logic [IDX_W-1:0]            rd_addr;

    assign cnt_dec    = cnt_reg - CNT_W'(1);
    assign scan_issue = ctl.scan_step && (k_reg < cnt_reg);
    assign scan_addr  = ring_add(front_reg, k_reg[IDX_W-1:0]);

    assign sts.cmd        = cmd_reg;
    assign sts.empty      = (cnt_reg == '0);
    assign sts.full       = (cnt_reg >= DEPTH_CNT);
    assign sts.scan_done  = (k_reg == cnt_reg) && !rd_pend_reg;
    assign sts.both_found = f1_reg && f2_reg;

    // Memory port selection.
    always_comb
    begin
        mem_we  = 1'b0;
        wr_addr = ring_add(front_reg, cnt_reg[IDX_W-1:0]);
        wr_data = h1_reg;
        if (ctl.put)
        begin
            mem_we = 1'b1;
        end
        else if (ctl.swap_first)
        begin
            mem_we  = 1'b1;
            wr_addr = p1_reg;
            wr_data = h2_reg;
        end
        else if (ctl.swap_second)
        begin
            mem_we  = 1'b1;
            wr_addr = p2_reg;
            wr_data = h1_reg;
        end

        mem_re  = ctl.rd_front || ctl.rd_back || scan_issue;
        rd_addr = front_reg;
        if (ctl.rd_back)
        begin
            rd_addr = ring_add(front_reg, cnt_dec[IDX_W-1:0]);
        end
        else if (scan_issue)
        begin
            rd_addr = scan_addr;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            slots_mem[wr_addr] <= wr_data;
        end
        if (mem_re)
        begin
            rd_data_reg <= slots_mem[rd_addr];
        end
    end

    // Ring pointer and fill count updates.
    always_comb
    begin
        front_next = front_reg;
        cnt_next   = cnt_reg;
        if (ctl.clear)
        begin
            front_next = '0;
            cnt_next   = '0;
        end
        else if (ctl.put)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (ctl.drop_back)
        begin
            cnt_next = cnt_dec;
            if (cnt_dec == '0)
            begin
                front_next = '0;
            end
        end
        else if (ctl.drop_front)
        begin
            cnt_next   = cnt_dec;
            front_next = (cnt_dec == '0) ? '0 : ring_add(front_reg, IDX_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg   <= '0;
            cnt_reg     <= '0;
            k_reg       <= '0;
            rd_pend_reg <= 1'b0;
            f1_reg      <= 1'b0;
            f2_reg      <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            front_reg <= front_next;
            cnt_reg   <= cnt_next;
            done_reg  <= ctl.resp;
            if (ctl.scan_start)
            begin
                k_reg       <= '0;
                rd_pend_reg <= 1'b0;
                f1_reg      <= 1'b0;
                f2_reg      <= 1'b0;
            end
            else if (ctl.scan_step)
            begin
                rd_pend_reg <= scan_issue;
                if (scan_issue)
                begin
                    k_reg <= k_reg + CNT_W'(1);
                end
                if (rd_pend_reg && !f1_reg && (rd_data_reg == h1_reg))
                begin
                    f1_reg <= 1'b1;
                end
                if (rd_pend_reg && !f2_reg && (rd_data_reg == h2_reg))
                begin
                    f2_reg <= 1'b1;
                end
            end
        end
    end

    // Transaction operands, search positions and the result word.
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg <= hdws_pkg::cmd_t'(cmd);
            h1_reg  <= handler;
            h2_reg  <= other_handler;
        end
        if (scan_issue)
        begin
            pos_d_reg <= scan_addr;
        end
        if (ctl.scan_step && rd_pend_reg)
        begin
            if (!f1_reg && (rd_data_reg == h1_reg))
            begin
                p1_reg <= pos_d_reg;
            end
            if (!f2_reg && (rd_data_reg == h2_reg))
            begin
                p2_reg <= pos_d_reg;
            end
        end
        if (ctl.resp)
        begin
            value_reg  <= ctl.resp_use_rd ? rd_data_reg : '0;
            status_reg <= ctl.resp_status;
            count_reg  <= hdws_pkg::COUNT_W'(cnt_next);
        end
    end

    assign value  = value_reg;
    assign status = status_reg;
    assign count  = count_reg;
    assign done   = done_reg;

endmodule

`default_nettype wire

/* sv/handler_deque_with_swap_top.sv */
// Top level of the handler deque with swap: controller plus datapath.
// Put, clear and refused commands are answered from the decode state, pop and peek from the
// read state, and swap from the scan state or, once both words are found, the second swap
// state. The swap scan reads one slot per cycle through the single read port of the slot memory.
// One transaction at a time; busy drops in the cycle done is high; the receiver cannot stall.
// Reset empties the deque at once; slot contents stay undefined until written.
`default_nettype none

module handler_deque_with_swap_top
#(
    parameter int DEPTH = hdws_pkg::DEPTH_DEFAULT
)
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic [2:0]                     cmd,
    input  wire logic [hdws_pkg::WORD_W-1:0]    handler,
    input  wire logic [hdws_pkg::WORD_W-1:0]    other_handler,
    output logic                                done,
    output logic [hdws_pkg::WORD_W-1:0]         value,
    output logic [1:0]                          status,
    output logic [hdws_pkg::COUNT_W-1:0]        count
);

    // The controller decodes each transaction and steps the datapath; the
    // datapath reports the fill state and the progress of the swap scan.
    hdws_pkg::ctl_t ctl;
    hdws_pkg::sts_t sts;

    hdws_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .ctl   (ctl),
        .busy  (busy)
    );

    // The datapath holds the ring of slots, the front pointer and the entry
    // count, and registers the result with a done strobe shown for exactly one cycle.
    hdws_dp
    #(
        .DEPTH (DEPTH)
    )
    u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .handler       (handler),
        .other_handler (other_handler),
        .ctl           (ctl),
        .sts           (sts),
        .value         (value),
        .status        (status),
        .count         (count),
        .done          (done)
    );

endmodule

`default_nettype wire

/* sv/hdws_checker.sv */
// Port-level checker for the handler deque with swap, bound to the top level.
`default_nettype none

module hdws_checker
(
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           start,
    input wire logic                           busy,
    input wire logic                           done,
    input wire logic [hdws_pkg::WORD_W-1:0]    value,
    input wire logic [1:0]                     status,
    input wire logic [hdws_pkg::COUNT_W-1:0]   count
);

    // An accepted transaction keeps the block busy in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after an accepted transaction");

    // A result only follows a cycle in which the block was busy.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result strobe without a transaction in progress");

    // Exactly one result per transaction: strobes never come back to back.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe lasted more than one cycle");

    // An empty report comes with a zero word and an empty deque.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == hdws_pkg::STS_EMPTY)) |-> ((value == '0) && (count == '0)))
        else $error("empty status with nonzero value or count");

endmodule

bind handler_deque_with_swap_top hdws_checker u_hdws_checker
(
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .value  (value),
    .status (status),
    .count  (count)
);

`default_nettype wire

/* bench/tb_handler_deque_with_swap_top.sv */
// Self-checking testbench for the handler deque with swap, with its own deque predictor.
`timescale 1ns / 100ps

module tb_handler_deque_with_swap_top;

    localparam int DEPTH       = hdws_pkg::DEPTH_DEFAULT;
    localparam int WORD_W      = hdws_pkg::WORD_W;
    localparam int COUNT_W     = hdws_pkg::COUNT_W;
    localparam int CYCLE_LIMIT = 300000;
    localparam int RANDOM_CMDS = 850;
    localparam int PHASE_LEN   = 60;
    // The slowest command is a successful swap over a full deque.
    localparam int DRAIN_WAIT  = DEPTH + 10;
    // Command code seven has no enum member; the block leaves the deque as it is and reports success.
    localparam logic [2:0] CMD_RESERVED = 3'd7;

    // One result of the block as the checker sees it.
    typedef struct packed {
        logic [WORD_W-1:0]  value;
        hdws_pkg::status_t  status;
        logic [COUNT_W-1:0] count;
    } reply_t;

    // One row of the directed stimulus. A row with reps above one sends the
    // same command several times with the handler word counting up. Where
    // fixed is set, the typed reply is the expectation instead of the predictor.
    typedef struct packed {
        logic [2:0]        op;
        logic [WORD_W-1:0] h;
        logic [WORD_W-1:0] o;
        int                reps;
        bit                fixed;
        reply_t            reply;
    } row_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    logic [2:0]          cmd = '0;
    logic [WORD_W-1:0]   handler = '0;
    logic [WORD_W-1:0]   other_handler = '0;
    logic                busy;
    logic                done;
    logic [WORD_W-1:0]   value;
    logic [1:0]          status;
    logic [COUNT_W-1:0]  count;

    // Predictor state: the ring of words, the front position and the fill level.
    logic [WORD_W-1:0]   ring_words [DEPTH];
    int                  ring_head = 0;
    int                  ring_fill = 0;

    // Replies predicted for accepted transactions, oldest first.
    reply_t              pending_replies [$];
    int                  mismatches = 0;
    int                  cycle_count = 0;

    handler_deque_with_swap_top #(.DEPTH(DEPTH)) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .cmd           (cmd),
        .handler       (handler),
        .other_handler (other_handler),
        .done          (done),
        .value         (value),
        .status        (status),
        .count         (count)
    );

    always #10 clk = ~clk;

    // ------------------------------------------------------------------
    // Deque predictor
    // ------------------------------------------------------------------

    // Ring position of the entry at the given distance from the front.
    function automatic int slot_at(input int offset);
        return (ring_head + offset) % DEPTH;
    endfunction

    // Searches from the front for the first entry holding the word.
    function automatic bit locate_word(input logic [WORD_W-1:0] w, output int pos);
        pos = 0;
        for (int k = 0; k < ring_fill; k++)
        begin
            if (ring_words[slot_at(k)] == w)
            begin
                pos = slot_at(k);
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // Applies one command to the predicted deque and returns the reply it causes.
    function automatic reply_t deque_apply(input logic [2:0] op, input logic [WORD_W-1:0] h,
                                           input logic [WORD_W-1:0] o);
        reply_t r;
        int     p1;
        int     p2;
        bit     found1;
        bit     found2;
        r.value  = '0;
        r.status = hdws_pkg::STS_OK;
        case (op)
            hdws_pkg::CMD_PUT_BACK:
            begin
                if (ring_fill >= DEPTH)
                    r.status = hdws_pkg::STS_FULL;
                else
                begin
                    ring_words[slot_at(ring_fill)] = h;
                    ring_fill++;
                end
            end
            hdws_pkg::CMD_POP_BACK:
            begin
                if (ring_fill == 0)
                    r.status = hdws_pkg::STS_EMPTY;
                else
                begin
                    r.value = ring_words[slot_at(ring_fill - 1)];
                    ring_fill--;
                    if (ring_fill == 0)
                        ring_head = 0;
                end
            end
            hdws_pkg::CMD_POP_FRONT:
            begin
                if (ring_fill == 0)
                    r.status = hdws_pkg::STS_EMPTY;
                else
                begin
                    r.value = ring_words[ring_head];
                    ring_fill--;
                    ring_head = (ring_fill == 0) ? 0 : slot_at(1);
                end
            end
            hdws_pkg::CMD_PEEK_FRONT:
            begin
                if (ring_fill == 0)
                    r.status = hdws_pkg::STS_EMPTY;
                else
                    r.value = ring_words[ring_head];
            end
            hdws_pkg::CMD_PEEK_BACK:
            begin
                if (ring_fill == 0)
                    r.status = hdws_pkg::STS_EMPTY;
                else
                    r.value = ring_words[slot_at(ring_fill - 1)];
            end
            hdws_pkg::CMD_CLEAR:
            begin
                ring_head = 0;
                ring_fill = 0;
            end
            hdws_pkg::CMD_SWAP:
            begin
                found1 = locate_word(h, p1);
                found2 = locate_word(o, p2);
                // When both words are equal both searches hit the same slot,
                // so the two writes below leave it as it was.
                if (found1 && found2)
                begin
                    ring_words[p1] = o;
                    ring_words[p2] = h;
                end
                else
                    r.status = hdws_pkg::STS_NOT_FOUND;
            end
            default:
            begin
                // The reserved code changes nothing and reports success.
            end
        endcase
        r.count = COUNT_W'(ring_fill);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Most fresh words come from a small pool so that duplicates sit in the
    // deque and the swap search has to pick the first match; the rest are
    // fully random so that every bit of the word toggles.
    function automatic logic [WORD_W-1:0] fresh_word();
        if ($urandom_range(0, 9) < 7)
            return 32'hC0DE_0000 + WORD_W'($urandom_range(0, 7));
        return $urandom;
    endfunction

    // A word that is currently held somewhere in the predicted deque.
    function automatic logic [WORD_W-1:0] held_word();
        return ring_words[slot_at($urandom_range(0, ring_fill - 1))];
    endfunction

    // Sends one command transaction. The sender first idles for a random
    // number of cycles (none in a burst), then raises start and holds the
    // fields until the block takes them at an edge where busy is low. The
    // expectation is queued at that same edge. Start is left high when the
    // next command follows without a gap, so it never drops and rises
    // within one time step.
    task automatic send_command(input logic [2:0] op, input logic [WORD_W-1:0] h,
                                input logic [WORD_W-1:0] o, input bit burst,
                                input bit fixed, input reply_t fixed_reply);
        int     gap;
        reply_t predicted;
        gap = burst ? 0 : $urandom_range(0, 17);
        if (gap != 0)
        begin
            // Junk on the fields while start is low must be ignored.
            start         <= 1'b0;
            cmd           <= 3'($urandom);
            handler       <= $urandom;
            other_handler <= $urandom;
            repeat (gap) @(posedge clk);
        end
        start         <= 1'b1;
        cmd           <= op;
        handler       <= h;
        other_handler <= o;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        predicted = deque_apply(op, h, o);
        pending_replies.push_back(fixed ? fixed_reply : predicted);
    endtask

    // ------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------

    // Each done strobe is compared field by field with the oldest expectation.
    // The check runs at the clock edge, before the block updates its outputs.
    always @(posedge clk)
    begin
        reply_t want;
        if (rst_n === 1'b1 && done === 1'b1)
        begin
            if (pending_replies.size() == 0)
            begin
                mismatches++;
                $display("%0t: result with no transaction pending: value %h status %0d count %0d",
                         $time, value, status, count);
            end
            else
            begin
                want = pending_replies[0];
                pending_replies.delete(0);
                if (value !== want.value)
                begin
                    mismatches++;
                    $display("%0t: value mismatch: expected %h, actual %h",
                             $time, want.value, value);
                end
                if (status !== want.status)
                begin
                    mismatches++;
                    $display("%0t: status mismatch: expected %0d, actual %0d",
                             $time, want.status, status);
                end
                if (count !== want.count)
                begin
                    mismatches++;
                    $display("%0t: count mismatch: expected %0d, actual %0d",
                             $time, want.count, count);
                end
            end
        end
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("%0t: no progress within the cycle limit", $time);
            $display("FAIL handler_deque_with_swap_top");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial
    begin
        row_t        plan [16];
        reply_t      none;
        int          phase_mood;
        bit          burst;
        int          put_pct;
        int          pop_pct;
        int          roll;
        int          rest;
        logic [2:0]  op;
        logic [WORD_W-1:0] h;
        logic [WORD_W-1:0] o;

        none = '0;
        for (int k = 0; k < DEPTH; k++)
            ring_words[k] = '0;

        // Directed part. The typed replies follow directly from the command
        // history above each row; the rest are left to the predictor.
        plan = '{
            // Pop and peek on an empty deque, swap on an empty deque, reserved code.
            '{hdws_pkg::CMD_POP_FRONT,  32'h0, 32'h0, 1, 1'b1,
              '{32'h0, hdws_pkg::STS_EMPTY, 5'd0}},
            '{hdws_pkg::CMD_PEEK_BACK,  32'h0, 32'h0, 1, 1'b1,
              '{32'h0, hdws_pkg::STS_EMPTY, 5'd0}},
            '{hdws_pkg::CMD_SWAP,       32'h0, 32'h0, 1, 1'b1,
              '{32'h0, hdws_pkg::STS_NOT_FOUND, 5'd0}},
            '{CMD_RESERVED,             32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 1'b1,
              '{32'h0, hdws_pkg::STS_OK, 5'd0}},
            // Extreme words, then swap them and look at both ends.
            '{hdws_pkg::CMD_PUT_BACK,   32'hFFFF_FFFF, 32'h0, 1, 1'b1,
              '{32'h0, hdws_pkg::STS_OK, 5'd1}},
            '{hdws_pkg::CMD_PUT_BACK,   32'h0, 32'hFFFF_FFFF, 1, 1'b1,
              '{32'h0, hdws_pkg::STS_OK, 5'd2}},
            '{hdws_pkg::CMD_PEEK_FRONT, 32'h0, 32'h0, 1, 1'b1,
              '{32'hFFFF_FFFF, hdws_pkg::STS_OK, 5'd2}},
            '{hdws_pkg::CMD_SWAP,       32'hFFFF_FFFF, 32'h0, 1, 1'b1,
              '{32'h0, hdws_pkg::STS_OK, 5'd2}},
            '{hdws_pkg::CMD_PEEK_BACK,  32'h0, 32'h0, 1, 1'b1,
              '{32'hFFFF_FFFF, hdws_pkg::STS_OK, 5'd2}},
            // Swap of a word with itself, and a swap with one word missing.
            '{hdws_pkg::CMD_SWAP,       32'h0, 32'h0, 1, 1'b1,
              '{32'h0, hdws_pkg::STS_OK, 5'd2}},
            '{hdws_pkg::CMD_SWAP,       32'h0, 32'h5A5A_5A5A, 1, 1'b1,
              '{32'h0, hdws_pkg::STS_NOT_FOUND, 5'd2}},
            // Fill the deque, then a put that must be refused.
            '{hdws_pkg::CMD_PUT_BACK,   32'h8000_0001, 32'h0, DEPTH - 2, 1'b0, none},
            '{hdws_pkg::CMD_PUT_BACK,   32'h1234_5678, 32'h0, 1, 1'b1,
              '{32'h0, hdws_pkg::STS_FULL, 5'(DEPTH)}},
            // After the swap the front holds zero and the next entry all ones.
            '{hdws_pkg::CMD_POP_FRONT,  32'h0, 32'h0, 1, 1'b1,
              '{32'h0, hdws_pkg::STS_OK, 5'(DEPTH - 1)}},
            '{hdws_pkg::CMD_POP_BACK,   32'h0, 32'h0, 1, 1'b0, none},
            '{hdws_pkg::CMD_CLEAR,      32'h0, 32'h0, 1, 1'b1,
              '{32'h0, hdws_pkg::STS_OK, 5'd0}}
        };

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            for (int r = 0; r < plan[i].reps; r++)
                send_command(plan[i].op, plan[i].h + WORD_W'(r), plan[i].o, 1'b0,
                             plan[i].fixed, plan[i].reply);
        end

        // Random part. The run moves through phases that favor growing,
        // shrinking or holding the deque, so that it spends time both near
        // empty and near full. Some phases run without any idle cycles.
        phase_mood = 0;
        burst      = 1'b0;
        put_pct    = 30;
        pop_pct    = 25;
        for (int n = 0; n < RANDOM_CMDS; n++)
        begin
            if (n % PHASE_LEN == 0)
            begin
                phase_mood = $urandom_range(0, 2);
                burst      = ($urandom_range(0, 3) == 0);
                put_pct    = (phase_mood == 0) ? 55 : (phase_mood == 1) ? 10 : 30;
                pop_pct    = (phase_mood == 0) ? 10 : (phase_mood == 1) ? 50 : 25;
            end

            roll = $urandom_range(0, 99);
            o    = $urandom;
            h    = fresh_word();
            if (roll < put_pct)
                op = hdws_pkg::CMD_PUT_BACK;
            else if (roll < put_pct + pop_pct)
                op = $urandom_range(0, 1) ? hdws_pkg::CMD_POP_FRONT : hdws_pkg::CMD_POP_BACK;
            else
            begin
                rest = $urandom_range(0, 19);
                if (rest < 5)
                    op = hdws_pkg::CMD_PEEK_FRONT;
                else if (rest < 10)
                    op = hdws_pkg::CMD_PEEK_BACK;
                else if (rest < 18)
                    op = hdws_pkg::CMD_SWAP;
                else if (rest == 18)
                    op = hdws_pkg::CMD_CLEAR;
                else
                    op = CMD_RESERVED;
            end

            // Most swaps name words that are present; the others name fresh
            // words that may or may not be held.
            if (op == hdws_pkg::CMD_SWAP)
            begin
                if (ring_fill > 0 && $urandom_range(0, 3) != 0)
                    h = held_word();
                if (ring_fill > 0 && $urandom_range(0, 3) != 0)
                    o = held_word();
                else
                    o = fresh_word();
            end

            send_command(op, h, o, burst, 1'b0, none);
        end

        start <= 1'b0;

        // Let every outstanding result arrive, then watch a little longer
        // for any stray strobe.
        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (mismatches == 0)
            $display("PASS handler_deque_with_swap_top");
        else
            $display("FAIL handler_deque_with_swap_top");
        $finish;
    end

endmodule

/* handler_deque_with_swap_top.f */
sv/hdws_pkg.sv
sv/hdws_ctrl.sv
sv/hdws_dp.sv
sv/handler_deque_with_swap_top.sv
sv/hdws_checker.sv
bench/tb_handler_deque_with_swap_top.sv
